// File: hw/rtl/vcpa_pkg.sv
package vcpa_pkg;

    localparam int SLOTS_PER_REG    = 4;
    localparam int NUM_REGS_DEFAULT = 16;

    localparam logic [0:0] CMD_ALLOC = 1'b0;
    localparam logic [0:0] CMD_CLEAR = 1'b1;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_CLEARED = 2'd2;

    // one table entry as kept in the ram
    typedef struct packed {
        logic       kind;
        logic [2:0] used;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: hw/rtl/vcpa_ram.sv
module vcpa_ram #(
    parameter int WIDTH = vcpa_pkg::ENTRY_W,
    parameter int DEPTH = vcpa_pkg::NUM_REGS_DEFAULT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/vector_component_packing_allocator.sv
// channel   valid      stall      payload
// req       req_valid  req_stall  command, component_count, component_kind
// rsp       rsp_valid  rsp_stall  register_index, register_slot, data_offset,
//                                 piece_count, last_piece, status
//
// one request at a time; each open register costs a read state, then an evaluate state,
// per scan pass on the single read port of the table ram
// a request runs a first-fit pass, then a split pass if matching free slots suffice, else opens a new register
// clear and reset drop the open count to zero, with no ram sweep
// a stalled rsp holds the scan until the output register frees up
module vector_component_packing_allocator #(
    parameter int NUM_REGS = vcpa_pkg::NUM_REGS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       command,
    input  logic [2:0] component_count,
    input  logic       component_kind,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [3:0] register_index,
    output logic [1:0] register_slot,
    output logic [1:0] data_offset,
    output logic [2:0] piece_count,
    output logic       last_piece,
    output logic [1:0] status
);

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int RW = $clog2(NUM_REGS + 1);
    localparam int IW = (RW > 4) ? RW : 4;
    localparam logic [2:0] SLOTS = 3'(vcpa_pkg::SLOTS_PER_REG);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_DECIDE,
        S_CLEAR
    } state_t;

    state_t state_reg, state_next;

    logic [RW-1:0] open_reg, open_next;
    logic [RW-1:0] r_reg, r_next;
    logic          pass_reg, pass_next;
    logic [2:0]    need_reg, need_next;
    logic          kind_reg, kind_next;
    logic [2:0]    total_reg, total_next;
    logic [2:0]    placed_reg, placed_next;

    logic          rsp_valid_reg, rsp_valid_next;
    logic [3:0]    index_reg, index_next;
    logic [1:0]    slot_reg, slot_next;
    logic [1:0]    offset_reg, offset_next;
    logic [2:0]    count_reg, count_next;
    logic          last_reg, last_next;
    logic [1:0]    status_reg, status_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    vcpa_pkg::entry_t   ram_wdata;
    logic               ram_re;
    vcpa_pkg::entry_t   ram_rdata;

    logic          out_free;
    logic [2:0]    need_clamped;
    logic [2:0]    fr;
    logic [2:0]    remain;
    logic [2:0]    take;
    logic [3:0]    total_sum;
    logic          match;
    logic [IW-1:0] r_ext;
    logic [IW-1:0] open_ext;

    vcpa_ram #(
        .WIDTH (vcpa_pkg::ENTRY_W),
        .DEPTH (NUM_REGS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (r_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign need_clamped = (component_count == 3'd0) ? 3'd1 :
                          (component_count > SLOTS) ? SLOTS : component_count;
    assign match        = (ram_rdata.kind == kind_reg);
    assign fr           = (ram_rdata.used < SLOTS) ? 3'(SLOTS - ram_rdata.used) : 3'd0;
    assign remain       = 3'(need_reg - placed_reg);
    assign take         = (remain < fr) ? remain : fr;
    assign total_sum    = {1'b0, total_reg} + {1'b0, (match ? fr : 3'd0)};
    assign r_ext        = IW'(r_reg);
    assign open_ext     = IW'(open_reg);

    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        r_next         = r_reg;
        pass_next      = pass_reg;
        need_next      = need_reg;
        kind_next      = kind_reg;
        total_next     = total_reg;
        placed_next    = placed_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        index_next     = index_reg;
        slot_next      = slot_reg;
        offset_next    = offset_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = r_reg[AW-1:0];
        ram_wdata      = '{kind: kind_reg, used: 3'd0};
        ram_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    need_next   = need_clamped;
                    kind_next   = component_kind;
                    r_next      = '0;
                    pass_next   = 1'b0;
                    total_next  = 3'd0;
                    placed_next = 3'd0;
                    state_next  = (command == vcpa_pkg::CMD_CLEAR) ? S_CLEAR : S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (r_reg >= open_reg)
                begin
                    state_next = pass_reg ? S_IDLE : S_DECIDE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                if (!pass_reg)
                begin
                    if (match && fr >= need_reg)
                    begin
                        if (out_free)
                        begin
                            ram_we         = 1'b1;
                            ram_wdata.used = 3'(ram_rdata.used + need_reg);
                            rsp_valid_next = 1'b1;
                            index_next     = r_ext[3:0];
                            slot_next      = ram_rdata.used[1:0];
                            offset_next    = 2'd0;
                            count_next     = need_reg;
                            last_next      = 1'b1;
                            status_next    = vcpa_pkg::ST_PLACED;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        total_next = (total_sum > 4'(SLOTS)) ? SLOTS : total_sum[2:0];
                        r_next     = RW'(r_reg + 1'b1);
                        state_next = S_SCAN;
                    end
                end
                else if (match && fr != 3'd0)
                begin
                    if (out_free)
                    begin
                        ram_we         = 1'b1;
                        ram_wdata.used = 3'(ram_rdata.used + take);
                        rsp_valid_next = 1'b1;
                        index_next     = r_ext[3:0];
                        slot_next      = ram_rdata.used[1:0];
                        offset_next    = placed_reg[1:0];
                        count_next     = take;
                        last_next      = (take == remain);
                        status_next    = vcpa_pkg::ST_PLACED;
                        placed_next    = 3'(placed_reg + take);
                        r_next         = RW'(r_reg + 1'b1);
                        state_next     = (take == remain) ? S_IDLE : S_SCAN;
                    end
                end
                else
                begin
                    r_next     = RW'(r_reg + 1'b1);
                    state_next = S_SCAN;
                end
            end

            S_DECIDE:
            begin
                if (total_reg >= need_reg)
                begin
                    pass_next   = 1'b1;
                    r_next      = '0;
                    placed_next = 3'd0;
                    state_next  = S_SCAN;
                end
                else if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    slot_next      = 2'd0;
                    offset_next    = 2'd0;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                    if (open_reg >= RW'(NUM_REGS))
                    begin
                        index_next  = 4'd0;
                        count_next  = 3'd0;
                        status_next = vcpa_pkg::ST_FULL;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ram_waddr      = open_reg[AW-1:0];
                        ram_wdata.used = need_reg;
                        open_next      = RW'(open_reg + 1'b1);
                        index_next     = open_ext[3:0];
                        count_next     = need_reg;
                        status_next    = vcpa_pkg::ST_PLACED;
                    end
                end
            end

            S_CLEAR:
            begin
                if (out_free)
                begin
                    open_next      = '0;
                    rsp_valid_next = 1'b1;
                    index_next     = 4'd0;
                    slot_next      = 2'd0;
                    offset_next    = 2'd0;
                    count_next     = 3'd0;
                    last_next      = 1'b1;
                    status_next    = vcpa_pkg::ST_CLEARED;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            open_reg      <= '0;
            r_reg         <= '0;
            pass_reg      <= 1'b0;
            need_reg      <= 3'd1;
            kind_reg      <= 1'b0;
            total_reg     <= 3'd0;
            placed_reg    <= 3'd0;
            rsp_valid_reg <= 1'b0;
            index_reg     <= 4'd0;
            slot_reg      <= 2'd0;
            offset_reg    <= 2'd0;
            count_reg     <= 3'd0;
            last_reg      <= 1'b0;
            status_reg    <= vcpa_pkg::ST_PLACED;
        end
        else
        begin
            state_reg     <= state_next;
            open_reg      <= open_next;
            r_reg         <= r_next;
            pass_reg      <= pass_next;
            need_reg      <= need_next;
            kind_reg      <= kind_next;
            total_reg     <= total_next;
            placed_reg    <= placed_next;
            rsp_valid_reg <= rsp_valid_next;
            index_reg     <= index_next;
            slot_reg      <= slot_next;
            offset_reg    <= offset_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            status_reg    <= status_next;
        end
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign rsp_valid      = rsp_valid_reg;
    assign register_index = index_reg;
    assign register_slot  = slot_reg;
    assign data_offset    = offset_reg;
    assign piece_count    = count_reg;
    assign last_piece     = last_reg;
    assign status         = status_reg;

`ifndef SYNTHESIS
    // open count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= RW'(NUM_REGS))
        else $error("open register count beyond table size");

    // table updates only go along with a result transfer slot
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> out_free)
        else $error("table write while result register blocked");

    // a placed piece is nonempty and fits inside its register
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == vcpa_pkg::ST_PLACED) |->
            (piece_count != 3'd0 && ({1'b0, register_slot} + piece_count) <= SLOTS))
        else $error("placed piece out of register bounds");

    // a scan pass never reads past the open registers
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (r_reg < open_reg))
        else $error("table read beyond open registers");
`endif

endmodule
